/* src/i2cram_pkg.sv */
// Package for the I2C register access master.
// Holds the item types, the sequencer state encoding and fixed constants.
// Depends on nothing; used by all files in src.
package i2cram_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;

   localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd104;
   localparam logic [15:0] PHASE_TICKS_RESET    = 16'd1000;

   localparam logic [1:0] BYTE_ADDRESS  = 2'd0;
   localparam logic [1:0] BYTE_REGISTER = 2'd1;
   localparam logic [1:0] BYTE_DATA     = 2'd2;
   localparam logic [1:0] BYTE_READ     = 2'd3;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef enum logic [0:0] {
      CSR_DEVICE_ADDRESS = 1'b0,
      CSR_PHASE_TICKS    = 1'b1
   } csr_index_type;

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_START_HI  = 13'b0000000000010,
      ST_START_LO  = 13'b0000000000100,
      ST_TX_LOW    = 13'b0000000001000,
      ST_TX_HIGH   = 13'b0000000010000,
      ST_ACK_LOW   = 13'b0000000100000,
      ST_ACK_HIGH  = 13'b0000001000000,
      ST_RX_LOW    = 13'b0000010000000,
      ST_RX_HIGH   = 13'b0000100000000,
      ST_NACK_LOW  = 13'b0001000000000,
      ST_NACK_HIGH = 13'b0010000000000,
      ST_STOP_LO   = 13'b0100000000000,
      ST_STOP_HI   = 13'b1000000000000
   } step_type;

   typedef struct packed {
      logic       request;
      logic       mode;
      logic [7:0] reg_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
   } rsp_type;

endpackage

/* src/i2cram_seq.sv */
// Bus sequencer of the I2C register access master.
// Holds the transaction state and computes the bus levels for one tick item.
// Depends on i2cram_pkg.
module i2cram_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  i2cram_pkg::req_type item,
   input  logic [6:0]          device_address,
   input  logic [15:0]         phase_ticks,
   output i2cram_pkg::rsp_type result
);

   i2cram_pkg::step_type step_ff, step_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;
   logic [1:0]  byte_cnt_ff, byte_cnt_in;
   logic [7:0]  tx_ff, tx_in;
   logic [7:0]  rx_ff, rx_in;
   logic [15:0] timer_ff, timer_in;
   logic        mode_ff, mode_in;
   logic [7:0]  reg_ff, reg_in;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  last_read_ff, last_read_in;

   always_comb begin
      logic [15:0] limit;
      logic [16:0] timer_next;
      logic [3:0]  bit_next;
      logic        scl;
      logic        drive;
      logic        level;
      logic        busy;
      logic        done;

      step_in      = step_ff;
      bit_cnt_in   = bit_cnt_ff;
      byte_cnt_in  = byte_cnt_ff;
      tx_in        = tx_ff;
      rx_in        = rx_ff;
      timer_in     = timer_ff;
      mode_in      = mode_ff;
      reg_in       = reg_ff;
      data_in      = data_ff;
      last_read_in = last_read_ff;
      scl          = 1'b1;
      drive        = 1'b0;
      level        = 1'b0;
      busy         = 1'b0;
      done         = 1'b0;
      limit        = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
      timer_next   = {1'b0, timer_ff} + 17'd1;
      bit_next     = bit_cnt_ff + 4'd1;

      if (step_ff == i2cram_pkg::ST_IDLE && item.request) begin
         mode_in     = item.mode;
         reg_in      = item.reg_address;
         data_in     = item.write_data;
         byte_cnt_in = i2cram_pkg::BYTE_ADDRESS;
         bit_cnt_in  = 4'd0;
         timer_in    = 16'd0;
         step_in     = i2cram_pkg::ST_START_HI;
         timer_next  = 17'd1;
         bit_next    = 4'd1;
      end

      case (step_in)
         i2cram_pkg::ST_START_HI: begin
            drive = 1'b1;
            level = 1'b1;
         end
         i2cram_pkg::ST_START_LO: begin
            drive = 1'b1;
         end
         i2cram_pkg::ST_TX_LOW: begin
            scl   = 1'b0;
            drive = 1'b1;
            level = tx_ff[7];
         end
         i2cram_pkg::ST_TX_HIGH: begin
            drive = 1'b1;
            level = tx_ff[7];
         end
         i2cram_pkg::ST_ACK_LOW, i2cram_pkg::ST_RX_LOW, i2cram_pkg::ST_NACK_LOW: begin
            scl = 1'b0;
         end
         i2cram_pkg::ST_STOP_LO: begin
            scl   = 1'b0;
            drive = 1'b1;
         end
         i2cram_pkg::ST_STOP_HI: begin
            drive = 1'b1;
         end
         default: begin
         end
      endcase

      if (step_in != i2cram_pkg::ST_IDLE) begin
         busy = 1'b1;
         if (timer_next < {1'b0, limit}) begin
            timer_in = timer_next[15:0];
         end else begin
            timer_in = 16'd0;
            case (step_in)
               i2cram_pkg::ST_START_HI: step_in = i2cram_pkg::ST_START_LO;
               i2cram_pkg::ST_START_LO: begin
                  tx_in      = {device_address, byte_cnt_in == i2cram_pkg::BYTE_READ};
                  bit_cnt_in = 4'd0;
                  step_in    = i2cram_pkg::ST_TX_LOW;
               end
               i2cram_pkg::ST_TX_LOW: step_in = i2cram_pkg::ST_TX_HIGH;
               i2cram_pkg::ST_TX_HIGH: begin
                  tx_in = {tx_ff[6:0], 1'b0};
                  if (bit_next >= 4'(i2cram_pkg::BITS_PER_BYTE)) begin
                     bit_cnt_in = 4'd0;
                     step_in    = i2cram_pkg::ST_ACK_LOW;
                  end else begin
                     bit_cnt_in = bit_next;
                     step_in    = i2cram_pkg::ST_TX_LOW;
                  end
               end
               i2cram_pkg::ST_ACK_LOW: step_in = i2cram_pkg::ST_ACK_HIGH;
               i2cram_pkg::ST_ACK_HIGH: begin
                  if (byte_cnt_in == i2cram_pkg::BYTE_ADDRESS) begin
                     byte_cnt_in = i2cram_pkg::BYTE_REGISTER;
                     tx_in       = reg_in;
                     bit_cnt_in  = 4'd0;
                     step_in     = i2cram_pkg::ST_TX_LOW;
                  end else if (byte_cnt_in == i2cram_pkg::BYTE_REGISTER &&
                               mode_in == i2cram_pkg::MODE_WRITE) begin
                     byte_cnt_in = i2cram_pkg::BYTE_DATA;
                     tx_in       = data_in;
                     bit_cnt_in  = 4'd0;
                     step_in     = i2cram_pkg::ST_TX_LOW;
                  end else if (byte_cnt_in == i2cram_pkg::BYTE_REGISTER) begin
                     byte_cnt_in = i2cram_pkg::BYTE_DATA;
                     step_in     = i2cram_pkg::ST_STOP_LO;
                  end else if (byte_cnt_in == i2cram_pkg::BYTE_READ &&
                               mode_in == i2cram_pkg::MODE_READ) begin
                     rx_in      = 8'd0;
                     bit_cnt_in = 4'd0;
                     step_in    = i2cram_pkg::ST_RX_LOW;
                  end else begin
                     step_in = i2cram_pkg::ST_STOP_LO;
                  end
               end
               i2cram_pkg::ST_RX_LOW: step_in = i2cram_pkg::ST_RX_HIGH;
               i2cram_pkg::ST_RX_HIGH: begin
                  rx_in = {rx_ff[6:0], item.sda_in};
                  if (bit_next >= 4'(i2cram_pkg::BITS_PER_BYTE)) begin
                     bit_cnt_in   = 4'd0;
                     last_read_in = rx_in;
                     step_in      = i2cram_pkg::ST_NACK_LOW;
                  end else begin
                     bit_cnt_in = bit_next;
                     step_in    = i2cram_pkg::ST_RX_LOW;
                  end
               end
               i2cram_pkg::ST_NACK_LOW: step_in = i2cram_pkg::ST_NACK_HIGH;
               i2cram_pkg::ST_NACK_HIGH: step_in = i2cram_pkg::ST_STOP_LO;
               i2cram_pkg::ST_STOP_LO: step_in = i2cram_pkg::ST_STOP_HI;
               i2cram_pkg::ST_STOP_HI: begin
                  if (mode_in == i2cram_pkg::MODE_READ &&
                      byte_cnt_in == i2cram_pkg::BYTE_DATA) begin
                     byte_cnt_in = i2cram_pkg::BYTE_READ;
                     step_in     = i2cram_pkg::ST_START_HI;
                  end else begin
                     step_in = i2cram_pkg::ST_IDLE;
                     done    = 1'b1;
                  end
               end
               default: step_in = i2cram_pkg::ST_IDLE;
            endcase
         end
      end

      result.scl_level = scl;
      result.sda_drive = drive;
      result.sda_level = level;
      result.busy_res  = busy;
      result.done_res  = done;
      result.read_data = last_read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= i2cram_pkg::ST_IDLE;
         bit_cnt_ff   <= 4'd0;
         byte_cnt_ff  <= 2'd0;
         tx_ff        <= 8'd0;
         rx_ff        <= 8'd0;
         timer_ff     <= 16'd0;
         mode_ff      <= 1'b0;
         reg_ff       <= 8'd0;
         data_ff      <= 8'd0;
         last_read_ff <= 8'd0;
      end else if (step_en) begin
         step_ff      <= step_in;
         bit_cnt_ff   <= bit_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         tx_ff        <= tx_in;
         rx_ff        <= rx_in;
         timer_ff     <= timer_in;
         mode_ff      <= mode_in;
         reg_ff       <= reg_in;
         data_ff      <= data_in;
         last_read_ff <= last_read_in;
      end
   end

   a_hold_without_item: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(step_ff) && $stable(timer_ff))
      else $error("sequencer state moved without an item");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_cnt_ff < 4'(i2cram_pkg::BITS_PER_BYTE))
      else $error("bit counter out of range");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      step_ff == i2cram_pkg::ST_IDLE |-> timer_ff == 16'd0)
      else $error("phase timer running while idle");

endmodule

/* src/i2c_register_access_master.sv */
// Top level of the I2C register access master.
// Holds the configuration registers, the result register and the handshakes.
// Depends on i2cram_pkg and i2cram_seq.

// Each accepted item is one bus tick, and the block takes one item in every clock
// cycle while the result side keeps up; its result is registered in the result
// register in the cycle after acceptance. The sequencer computes one full state
// step combinationally between its state registers and the result register.
// A new item is taken while a finished result waits, as long as that result is
// delivered in the same cycle. device_address (index 0) and phase_ticks (index 1)
// are written through the csr_ port and take effect on the next item.
module i2c_register_access_master (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  i2cram_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output i2cram_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   logic [6:0]  dev_addr_ff;
   logic [15:0] phase_ticks_ff;
   logic        rsp_valid_ff;
   i2cram_pkg::rsp_type rsp_data_ff;
   i2cram_pkg::rsp_type step_result;
   logic        accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   i2cram_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .step_en        (accept),
      .item           (req_data),
      .device_address (dev_addr_ff),
      .phase_ticks    (phase_ticks_ff),
      .result         (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= i2cram_pkg::DEVICE_ADDRESS_RESET;
         phase_ticks_ff <= i2cram_pkg::PHASE_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            i2cram_pkg::CSR_DEVICE_ADDRESS: dev_addr_ff <= csr_wdata[6:0];
            i2cram_pkg::CSR_PHASE_TICKS:    phase_ticks_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= step_result;
      end
   end

   a_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.busy_res)
      else $error("done item without busy");

   a_idle_bus_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |-> rsp_data.scl_level && !rsp_data.sda_drive)
      else $error("bus driven while idle");

   a_level_needs_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.sda_drive |-> !rsp_data.sda_level)
      else $error("data level set while released");

   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item produced no result");

endmodule

/* bench/i2cram_bench_pkg.sv */
`timescale 1ns / 100ps
// Bus tick checker for the I2C register access master bench: a cycle-true predictor
// of the sequencer and the queue of bus levels it expects. Depends on i2cram_pkg.
package i2cram_bench_pkg;
   import i2cram_pkg::*;

   class bus_tick_checker;
      logic [6:0]  device_address;
      logic [15:0] phase_ticks;
      step_type    bus_step;
      logic [3:0]  bit_count;
      logic [1:0]  byte_count;
      logic [7:0]  tx_shift;
      logic [7:0]  rx_shift;
      logic [15:0] phase_count;
      logic        held_mode;
      logic [7:0]  held_register;
      logic [7:0]  held_data;
      logic [7:0]  last_read;
      rsp_type     awaited_levels[$];
      int unsigned failures;
      int unsigned ticks_checked;
      int unsigned transfers_done;
      int unsigned settings_used;

      function new();
         device_address = DEVICE_ADDRESS_RESET;
         phase_ticks    = PHASE_TICKS_RESET;
         bus_step       = ST_IDLE;
         bit_count      = '0;
         byte_count     = BYTE_ADDRESS;
         tx_shift       = '0;
         rx_shift       = '0;
         phase_count    = '0;
         held_mode      = MODE_WRITE;
         held_register  = '0;
         held_data      = '0;
         last_read      = '0;
         failures       = 0;
         ticks_checked  = 0;
         transfers_done = 0;
         settings_used  = 1;
      endfunction

      function void set_register(csr_index_type index, logic [15:0] value);
         case (index)
            CSR_DEVICE_ADDRESS: device_address = value[6:0];
            CSR_PHASE_TICKS: begin
               phase_ticks = value;
               settings_used++;
            end
            default: ;
         endcase
      endfunction

      function bit bus_idle();
         return bus_step == ST_IDLE;
      endfunction

      function int unsigned awaiting();
         return awaited_levels.size();
      endfunction

      function void load_byte(logic [7:0] value);
         tx_shift  = value;
         bit_count = '0;
         bus_step  = ST_TX_LOW;
      endfunction

      function void predict_bus_tick(req_type item);
         rsp_type     levels;
         logic [15:0] period;
         levels = '0;
         levels.scl_level = 1'b1;
         if (bus_step == ST_IDLE && item.request) begin
            held_mode     = item.mode;
            held_register = item.reg_address;
            held_data     = item.write_data;
            byte_count    = BYTE_ADDRESS;
            bit_count     = '0;
            phase_count   = '0;
            bus_step      = ST_START_HI;
         end
         case (bus_step)
            ST_START_HI: begin
               levels.sda_drive = 1'b1;
               levels.sda_level = 1'b1;
            end
            ST_START_LO: levels.sda_drive = 1'b1;
            ST_TX_LOW: begin
               levels.scl_level = 1'b0;
               levels.sda_drive = 1'b1;
               levels.sda_level = tx_shift[7];
            end
            ST_TX_HIGH: begin
               levels.sda_drive = 1'b1;
               levels.sda_level = tx_shift[7];
            end
            ST_ACK_LOW, ST_RX_LOW, ST_NACK_LOW: levels.scl_level = 1'b0;
            ST_STOP_LO: begin
               levels.scl_level = 1'b0;
               levels.sda_drive = 1'b1;
            end
            ST_STOP_HI: levels.sda_drive = 1'b1;
            default: ;
         endcase
         if (bus_step != ST_IDLE) begin
            levels.busy_res = 1'b1;
            period = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
            if ({1'b0, phase_count} + 17'd1 < {1'b0, period}) begin
               phase_count = phase_count + 16'd1;
            end else begin
               phase_count = '0;
               case (bus_step)
                  ST_START_HI: bus_step = ST_START_LO;
                  ST_START_LO: load_byte({device_address, byte_count == BYTE_READ});
                  ST_TX_LOW: bus_step = ST_TX_HIGH;
                  ST_TX_HIGH: begin
                     tx_shift  = tx_shift << 1;
                     bit_count = bit_count + 4'd1;
                     if (bit_count >= BITS_PER_BYTE) begin
                        bit_count = '0;
                        bus_step  = ST_ACK_LOW;
                     end else begin
                        bus_step = ST_TX_LOW;
                     end
                  end
                  ST_ACK_LOW: bus_step = ST_ACK_HIGH;
                  ST_ACK_HIGH: begin
                     if (byte_count == BYTE_ADDRESS) begin
                        byte_count = BYTE_REGISTER;
                        load_byte(held_register);
                     end else if (byte_count == BYTE_REGISTER) begin
                        byte_count = BYTE_DATA;
                        if (held_mode == MODE_WRITE) begin
                           load_byte(held_data);
                        end else begin
                           bus_step = ST_STOP_LO;
                        end
                     end else if (byte_count == BYTE_READ && held_mode == MODE_READ) begin
                        rx_shift  = '0;
                        bit_count = '0;
                        bus_step  = ST_RX_LOW;
                     end else begin
                        bus_step = ST_STOP_LO;
                     end
                  end
                  ST_RX_LOW: bus_step = ST_RX_HIGH;
                  ST_RX_HIGH: begin
                     rx_shift  = {rx_shift[6:0], item.sda_in};
                     bit_count = bit_count + 4'd1;
                     if (bit_count >= BITS_PER_BYTE) begin
                        bit_count = '0;
                        last_read = rx_shift;
                        bus_step  = ST_NACK_LOW;
                     end else begin
                        bus_step = ST_RX_LOW;
                     end
                  end
                  ST_NACK_LOW: bus_step = ST_NACK_HIGH;
                  ST_NACK_HIGH: bus_step = ST_STOP_LO;
                  ST_STOP_LO: bus_step = ST_STOP_HI;
                  ST_STOP_HI: begin
                     // A read turns around here with a stop and then a new start for the data phase.
                     if (held_mode == MODE_READ && byte_count == BYTE_DATA) begin
                        byte_count = BYTE_READ;
                        bus_step   = ST_START_HI;
                     end else begin
                        bus_step = ST_IDLE;
                        levels.done_res = 1'b1;
                     end
                  end
                  default: bus_step = ST_IDLE;
               endcase
            end
         end
         levels.read_data = last_read;
         awaited_levels.push_back(levels);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            failures++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         end
      endfunction

      function void check_bus_tick(rsp_type got);
         rsp_type want;
         if (awaited_levels.size() == 0) begin
            failures++;
            $display("%0t: result %p arrived with nothing expected", $time, got);
            return;
         end
         want = awaited_levels.pop_front();
         ticks_checked++;
         compare_field("scl_level", want.scl_level, got.scl_level);
         compare_field("sda_drive", want.sda_drive, got.sda_drive);
         compare_field("sda_level", want.sda_level, got.sda_level);
         compare_field("busy_res", want.busy_res, got.busy_res);
         compare_field("done_res", want.done_res, got.done_res);
         compare_field("read_data", want.read_data, got.read_data);
         if (want.done_res && got.done_res) transfers_done++;
      endfunction
   endclass

endpackage

/* bench/i2c_register_access_master_tb.sv */
`timescale 1ns / 100ps
// Top of the I2C register access master bench: drives bus ticks and register writes
// with random gaps and stalls, and checks every result. Depends on i2cram_pkg,
// i2cram_bench_pkg and the RTL in src.
module i2c_register_access_master_tb;
   import i2cram_pkg::*;
   import i2cram_bench_pkg::*;

   typedef enum int {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_fill_type;

   localparam int unsigned TICK_TARGET = 1750;
   localparam int unsigned TICK_LIMIT  = 1000000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   bit              steady = 1'b0;
   int unsigned     ticks_sent = 0;
   int unsigned     phase;
   bus_tick_checker bus_model = new();

   i2c_register_access_master u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) bus_model.check_bus_tick(rsp_data);
      rsp_stall <= !steady && ($urandom_range(99) < 38);
   end

   function automatic req_type random_tick(logic request);
      req_type item;
      item.request     = request;
      item.mode        = 1'($urandom_range(0, 1));
      item.reg_address = 8'($urandom_range(0, 255));
      item.write_data  = 8'($urandom_range(0, 255));
      item.sda_in      = 1'($urandom_range(0, 1));
      return item;
   endfunction

   task automatic send_tick(input req_type item);
      while (!steady && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bus_model.predict_bus_tick(item);
      ticks_sent++;
   endtask

   task automatic run_ticks(input sda_fill_type sda_fill, input int unsigned max_ticks);
      req_type     item;
      int unsigned count;
      count = 0;
      while (!bus_model.bus_idle() && count < max_ticks) begin
         item = random_tick($urandom_range(99) < 25);
         if (sda_fill == SDA_HIGH) item.sda_in = 1'b1;
         else if (sda_fill == SDA_LOW) item.sda_in = 1'b0;
         send_tick(item);
         count++;
      end
   endtask

   task automatic run_transfer(input logic mode, input logic [7:0] reg_address,
                               input logic [7:0] write_data, input sda_fill_type sda_fill,
                               input int unsigned max_ticks);
      req_type item;
      item             = random_tick(1'b1);
      item.mode        = mode;
      item.reg_address = reg_address;
      item.write_data  = write_data;
      if (sda_fill == SDA_HIGH) item.sda_in = 1'b1;
      else if (sda_fill == SDA_LOW) item.sda_in = 1'b0;
      send_tick(item);
      run_ticks(sda_fill, max_ticks - 1);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (bus_model.awaiting() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [6:0] address, input logic [15:0] period);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_DEVICE_ADDRESS;
      csr_wdata <= {9'd0, address};
      @(posedge clock);
      bus_model.set_register(CSR_DEVICE_ADDRESS, {9'd0, address});
      csr_index <= CSR_PHASE_TICKS;
      csr_wdata <= period;
      @(posedge clock);
      bus_model.set_register(CSR_PHASE_TICKS, period);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, then a change of period and address in the middle of a read.
      run_transfer(MODE_READ, 8'hA5, 8'h3C, SDA_RANDOM, 20);
      configure(7'd127, 16'd0);
      run_ticks(SDA_HIGH, TICK_LIMIT);
      run_transfer(MODE_WRITE, 8'hFF, 8'h00, SDA_RANDOM, TICK_LIMIT);
      run_transfer(MODE_WRITE, 8'h00, 8'hFF, SDA_HIGH, TICK_LIMIT);
      run_transfer(MODE_READ, 8'h00, 8'hFF, SDA_LOW, TICK_LIMIT);
      configure(7'd0, 16'd1);
      run_transfer(MODE_READ, 8'hFF, 8'h00, SDA_RANDOM, TICK_LIMIT);
      configure(7'h55, 16'd2);
      run_transfer(MODE_WRITE, 8'h81, 8'h7E, SDA_RANDOM, TICK_LIMIT);
      configure(7'h2A, 16'hFFFF);
      run_transfer(MODE_WRITE, 8'h5A, 8'hC3, SDA_RANDOM, 40);
      configure(7'h2A, 16'd1);
      run_ticks(SDA_RANDOM, TICK_LIMIT);

      phase = 0;
      while (ticks_sent < TICK_TARGET) begin
         steady = (phase == 2 || phase == 3);
         configure(($urandom_range(0, 9) == 0) ? 7'd0 :
                   ($urandom_range(0, 9) == 0) ? 7'd127 : 7'($urandom_range(0, 127)),
                   ($urandom_range(0, 19) == 0) ? 16'd0 :
                   ($urandom_range(0, 9) == 0) ? 16'd3 :
                   ($urandom_range(0, 5) == 0) ? 16'd2 : 16'd1);
         repeat ($urandom_range(2, 4)) begin
            run_ticks(SDA_RANDOM, TICK_LIMIT);
            repeat ($urandom_range(0, 3)) send_tick(random_tick(1'b0));
            run_transfer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), SDA_RANDOM,
                         ($urandom_range(99) < 15) ? $urandom_range(5, 60) : TICK_LIMIT);
         end
         phase++;
      end

      steady = 1'b0;
      wait_for_results();
      repeat (20) @(posedge clock);
      $display("Checked %0d bus ticks across %0d period settings; %0d transfers finished.",
               bus_model.ticks_checked, bus_model.settings_used, bus_model.transfers_done);
      $display("Writes, reads, ignored requests and mid-transfer register changes included.");
      if (bus_model.failures == 0 && bus_model.awaiting() == 0) begin
         $display("i2c_register_access_master_tb: PASS");
      end else begin
         $display("i2c_register_access_master_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("Timed out with %0d results still expected.", bus_model.awaiting());
      $display("i2c_register_access_master_tb: FAIL");
      $finish;
   end

endmodule
